@@ rtl/core/apsp_pkg.sv @@
// Shared types and constants of the all-pairs shortest path block.
package apsp_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int ADDR_W       = 2 * VIDX_W;
  localparam int VC_W         = 5;
  localparam int WEIGHT_W     = 16;
  localparam int DIST_W       = 32;

  localparam logic [VC_W-1:0] VC_RESET = VC_W'(16);

  // Saturation bounds of a relaxed sum.
  localparam logic signed [DIST_W:0] DIST_MAX = 33'sd2147483646;
  localparam logic signed [DIST_W:0] DIST_MIN = -33'sd2147483647;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_SET   = 2'd1,
    OP_SOLVE = 2'd2,
    OP_READ  = 2'd3
  } apsp_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_ROW,
    ST_ROW_WAIT,
    ST_FETCH,
    ST_SUM,
    ST_UPDATE
  } apsp_state_e;

endpackage

@@ rtl/core/apsp_dist_ram.sv @@
// Distance memory: one write port, two registered read ports.
module apsp_dist_ram #(
  parameter int DataW = 32,
  parameter int AddrW = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_a_i,
  input  logic [AddrW-1:0] raddr_a_i,
  output logic [DataW-1:0] rdata_a_o,
  input  logic             re_b_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [DataW-1:0] rdata_b_o
);

  logic [DataW-1:0] mem [(1 << AddrW)];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_a_i) begin
      rdata_a_o <= mem[raddr_a_i];
    end
    if (re_b_i) begin
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule

@@ rtl/core/apsp_relax.sv @@
// Shared relaxation unit: saturating add into a register, then compare.
module apsp_relax (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [apsp_pkg::DIST_W-1:0]  dik_i,
  input  logic signed [apsp_pkg::DIST_W-1:0]  dkj_i,
  input  logic signed [apsp_pkg::DIST_W-1:0]  dij_i,
  output logic signed [apsp_pkg::DIST_W-1:0]  sum_o,
  output logic                                take_o
);
  import apsp_pkg::*;

  logic signed [DIST_W:0]   sum_full;
  logic signed [DIST_W-1:0] sum_sat;
  logic signed [DIST_W-1:0] sum_q;
  logic signed [DIST_W-1:0] dij_q;

  assign sum_full = {dik_i[DIST_W-1], dik_i} + {dkj_i[DIST_W-1], dkj_i};

  always_comb begin
    if (sum_full > DIST_MAX) begin
      sum_sat = DIST_MAX[DIST_W-1:0];
    end else if (sum_full < DIST_MIN) begin
      sum_sat = DIST_MIN[DIST_W-1:0];
    end else begin
      sum_sat = sum_full[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= sum_sat;
      dij_q <= dij_i;
    end
  end

  assign sum_o  = sum_q;
  assign take_o = sum_q < dij_q;

endmodule

@@ rtl/core/all_pairs_shortest_path.sv @@
// Top level of the all-pairs shortest path block: sequencer, marks and result register.
//
// An item is taken when start is high and busy is low; exactly one result follows
// on done_o for a single cycle, and the receiver cannot hold it off, so capture it
// then. A clear sweeps the diagonal of the vertices in use, one diagonal entry written
// per cycle. Solve runs Floyd-Warshall through one shared add/compare unit and
// a two-read, one-write distance memory: a (k, i) pair whose i cannot reach k is
// skipped, else d[i][k] is read and held; then a column that k does not reach is
// skipped, else it is fetched, added, compared and written back. busy stays high
// until an operation ends; a set edge is done in the accepting cycle and never raises it.
// The vertex count is to be written through cfg_we_i / cfg_data_i only while idle;
// the block does not enforce this. Values of zero act as one and values above the
// table size act as the table size.
module all_pairs_shortest_path (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           operation_i,
  input  logic [apsp_pkg::VIDX_W-1:0]          source_vertex_i,
  input  logic [apsp_pkg::VIDX_W-1:0]          target_vertex_i,
  input  logic signed [apsp_pkg::WEIGHT_W-1:0] edge_weight_i,
  input  logic                                 cfg_we_i,
  input  logic [apsp_pkg::VC_W-1:0]            cfg_data_i,
  output logic                                 done_o,
  output logic signed [apsp_pkg::DIST_W-1:0]   path_distance_o,
  output logic                                 unreachable_o,
  output logic [1:0]                           operation_done_o
);
  import apsp_pkg::*;

  localparam int DEPTH = 1 << ADDR_W;

  apsp_state_e state_q, state_d;
  apsp_op_e    op_in, op_q, op_d;

  logic [VC_W-1:0]   vc_q;
  logic [VC_W-1:0]   n_active, n_active_m1;
  logic [VIDX_W-1:0] n_last;
  logic [VIDX_W-1:0] k_q, k_d, i_q, i_d, j_q, j_d;
  logic [DEPTH-1:0]  mark_q;
  logic              read_miss_q, read_miss_d;
  logic              accept, in_range;

  // memory and unit controls
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [DIST_W-1:0] mem_wdata;
  logic              rd_a_en, rd_b_en;
  logic [ADDR_W-1:0] rd_a_addr, rd_b_addr;
  logic [DIST_W-1:0] rd_a_data, rd_b_data;
  logic              mark_clr_all;
  logic              dik_load_mem, dik_load_sum;
  logic              relax_en, relax_take;
  logic signed [DIST_W-1:0] relax_sum;
  logic signed [DIST_W-1:0] dik_q;
  logic              adv_col, adv_row;

  // result staging
  logic              res_valid;
  apsp_op_e          res_op;
  logic [DIST_W-1:0] res_dist;
  logic              res_unreach;
  logic              done_q;
  apsp_op_e          op_done_q;
  logic [DIST_W-1:0] dist_q;
  logic              unreach_q;

  assign op_in  = apsp_op_e'(operation_i);
  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  // Clamp the vertex count into the legal range.
  always_comb begin
    if (vc_q == '0) begin
      n_active = VC_W'(1);
    end else if (vc_q > VC_W'(MAX_VERTICES)) begin
      n_active = VC_W'(MAX_VERTICES);
    end else begin
      n_active = vc_q;
    end
  end
  assign n_active_m1 = n_active - VC_W'(1);
  assign n_last      = n_active_m1[VIDX_W-1:0];
  assign in_range    = (source_vertex_i <= n_last) && (target_vertex_i <= n_last);

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= VC_RESET;
    end else if (cfg_we_i) begin
      vc_q <= cfg_data_i;
    end
  end

  // Sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_CLEAR;
      k_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      read_miss_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      k_q         <= k_d;
      i_q         <= i_d;
      j_q         <= j_d;
      read_miss_q <= read_miss_d;
    end
  end

  // Next state, loop counters and datapath controls.
  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    k_d          = k_q;
    i_d          = i_q;
    j_d          = j_q;
    read_miss_d  = read_miss_q;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    rd_a_en      = 1'b0;
    rd_a_addr    = '0;
    rd_b_en      = 1'b0;
    rd_b_addr    = '0;
    mark_clr_all = 1'b0;
    dik_load_mem = 1'b0;
    dik_load_sum = 1'b0;
    relax_en     = 1'b0;
    adv_col      = 1'b0;
    adv_row      = 1'b0;
    res_valid    = 1'b0;
    res_op       = op_q;
    res_dist     = '0;
    res_unreach  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d = op_in;
          case (op_in)
            OP_CLEAR: begin
              // Drop every mark at once, then sweep the diagonal.
              mark_clr_all = 1'b1;
              i_d          = '0;
              state_d      = ST_CLEAR;
            end
            OP_SET: begin
              if (in_range) begin
                mem_we    = 1'b1;
                mem_waddr = {source_vertex_i, target_vertex_i};
                // A self edge is stored as distance zero, whatever its weight.
                mem_wdata = (source_vertex_i == target_vertex_i) ? '0 :
                            {{(DIST_W-WEIGHT_W){edge_weight_i[WEIGHT_W-1]}}, edge_weight_i};
              end
              res_valid = 1'b1;
              res_op    = op_in;
            end
            OP_SOLVE: begin
              k_d     = '0;
              i_d     = '0;
              state_d = ST_ROW;
            end
            OP_READ: begin
              rd_a_en     = 1'b1;
              rd_a_addr   = {source_vertex_i, target_vertex_i};
              read_miss_d = !(in_range && mark_q[{source_vertex_i, target_vertex_i}]);
              state_d     = ST_READ;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      ST_READ: begin
        res_valid   = 1'b1;
        res_dist    = read_miss_q ? '0 : rd_a_data;
        res_unreach = read_miss_q;
        state_d     = ST_IDLE;
      end

      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = {i_q, i_q};
        mem_wdata = '0;
        if (i_q == n_last) begin
          res_valid = 1'b1;
          state_d   = ST_IDLE;
        end else begin
          i_d = i_q + VIDX_W'(1);
        end
      end

      ST_ROW: begin
        // Skip the whole row when i cannot reach the intermediate vertex.
        if (mark_q[{i_q, k_q}]) begin
          rd_a_en   = 1'b1;
          rd_a_addr = {i_q, k_q};
          state_d   = ST_ROW_WAIT;
        end else begin
          adv_row = 1'b1;
        end
      end

      ST_ROW_WAIT: begin
        dik_load_mem = 1'b1;
        j_d          = '0;
        state_d      = ST_FETCH;
      end

      ST_FETCH: begin
        if (mark_q[{k_q, j_q}]) begin
          rd_a_en   = 1'b1;
          rd_a_addr = {k_q, j_q};
          rd_b_en   = 1'b1;
          rd_b_addr = {i_q, j_q};
          state_d   = ST_SUM;
        end else begin
          adv_col = 1'b1;
        end
      end

      ST_SUM: begin
        relax_en = 1'b1;
        state_d  = ST_UPDATE;
      end

      ST_UPDATE: begin
        if (!mark_q[{i_q, j_q}] || relax_take) begin
          mem_we    = 1'b1;
          mem_waddr = {i_q, j_q};
          mem_wdata = relax_sum;
          // Writing column k changes the held d[i][k] for later columns.
          dik_load_sum = (j_q == k_q);
        end
        adv_col = 1'b1;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (adv_col) begin
      if (j_q == n_last) begin
        adv_row = 1'b1;
      end else begin
        j_d     = j_q + VIDX_W'(1);
        state_d = ST_FETCH;
      end
    end

    if (adv_row) begin
      if (i_q != n_last) begin
        i_d     = i_q + VIDX_W'(1);
        state_d = ST_ROW;
      end else if (k_q != n_last) begin
        k_d     = k_q + VIDX_W'(1);
        i_d     = '0;
        state_d = ST_ROW;
      end else begin
        res_valid = 1'b1;
        state_d   = ST_IDLE;
      end
    end
  end

  // Reachable marks: one flip-flop per entry, set with every table write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q <= '0;
    end else if (mark_clr_all) begin
      mark_q <= '0;
    end else if (mem_we) begin
      mark_q[mem_waddr] <= 1'b1;
    end
  end

  // Hold d[i][k] for the current row.
  always_ff @(posedge clk_i) begin
    if (dik_load_mem) begin
      dik_q <= rd_a_data;
    end else if (dik_load_sum) begin
      dik_q <= relax_sum;
    end
  end

  apsp_dist_ram #(
    .DataW (DIST_W),
    .AddrW (ADDR_W)
  ) u_dist_ram (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .re_a_i    (rd_a_en),
    .raddr_a_i (rd_a_addr),
    .rdata_a_o (rd_a_data),
    .re_b_i    (rd_b_en),
    .raddr_b_i (rd_b_addr),
    .rdata_b_o (rd_b_data)
  );

  apsp_relax u_relax (
    .clk_i  (clk_i),
    .en_i   (relax_en),
    .dik_i  (dik_q),
    .dkj_i  (rd_a_data),
    .dij_i  (rd_b_data),
    .sum_o  (relax_sum),
    .take_o (relax_take)
  );

  // Result register: one cycle strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      op_done_q <= res_op;
      dist_q    <= res_dist;
      unreach_q <= res_unreach;
    end
  end

  assign done_o           = done_q;
  assign path_distance_o  = dist_q;
  assign unreachable_o    = unreach_q;
  assign operation_done_o = op_done_q;

  a_done_when_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == ST_IDLE))
    else $error("result strobe while an operation is still running");

  a_unreach_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && unreach_q) |-> (dist_q == '0 && op_done_q == OP_READ))
    else $error("unreachable result with a distance or from a non-read item");

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("sequencer left idle without an accepted item");

  a_write_only_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && state_q != ST_IDLE) |-> (mem_waddr[ADDR_W-1 -: VIDX_W] <= n_last))
    else $error("table write outside the vertices in use");

endmodule
